### hdl/wdof_pkg.sv
`timescale 1ns / 1ps

package wdof_pkg;

    localparam int ROM_LEN         = 45;
    localparam int OUI_ENTRIES_DEF = 45;
    localparam int OUI_W           = 24;
    localparam int VID_W           = 4;
    localparam int ADDR_W          = 48;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [11:0] MIN_FRAME_LEN = 12'd24;
    localparam logic [1:0]  TYPE_DATA     = 2'd2;

    // Bit positions inside a 48-bit address, first byte in bits 47:40.
    localparam int GROUP_BIT = 40;
    localparam int LOCAL_BIT = 41;

    localparam logic [OUI_W-1:0] ROM_OUI [ROM_LEN] = '{
        24'h00407F, 24'h2857BE, 24'h4419B6, 24'h4CBD8F,
        24'h880D8B, 24'hBCAD28, 24'hC0517E, 24'hC056E3,
        24'h14A78B, 24'h38AF29, 24'h3CEF8C, 24'h4C11BF,
        24'h644284, 24'h9C1463, 24'hA0BD1D,
        24'h9C8ECD,
        24'hD4F5EF, 24'hDC546B, 24'hEC71DB,
        24'h18B430, 24'h641666,
        24'hB009DA, 24'hB07FB9, 24'hFCA183,
        24'h2CAA8E, 24'h7C78B2, 24'hA4DA32,
        24'h8C8580, 24'h8C71F8,
        24'h001B11, 24'h0CDD24,
        24'h0008CA, 24'h50F14A, 24'h4C60DE,
        24'h00408C, 24'hACCC8E, 24'hB8A44F,
        24'h000918,
        24'h14EBB6, 24'h3C52A1, 24'hB04E26,
        24'h245A4C, 24'hF09FC2, 24'h687251,
        24'h001F5B
    };

    localparam logic [VID_W-1:0] ROM_VID [ROM_LEN] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd2,
        4'd3, 4'd3, 4'd3,
        4'd4, 4'd4,
        4'd5, 4'd5, 4'd5,
        4'd6, 4'd6, 4'd6,
        4'd7, 4'd7,
        4'd8, 4'd8,
        4'd9, 4'd9, 4'd9,
        4'd10, 4'd10, 4'd10,
        4'd11,
        4'd12, 4'd12, 4'd12,
        4'd13, 4'd13, 4'd13,
        4'd14
    };

    typedef struct packed {
        logic               is_data_packet;
        logic [11:0]        frame_length;
        logic [7:0]         frame_ctrl_lo;
        logic [7:0]         frame_ctrl_hi;
        logic [ADDR_W-1:0]  address_one;
        logic [ADDR_W-1:0]  address_two;
        logic [ADDR_W-1:0]  address_three;
        logic [3:0]         radio_channel;
        logic signed [7:0]  signal_strength;
    } frame_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  station_addr;
        logic [ADDR_W-1:0]  network_id;
        logic [VID_W-1:0]   vendor_id;
        logic [3:0]         channel_out;
        logic signed [7:0]  rssi_out;
    } alert_t;

endpackage

### hdl/wdof_front.sv
`timescale 1ns / 1ps

module wdof_front
    import wdof_pkg::*;
#(
    parameter int OUI_ENTRIES = OUI_ENTRIES_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   frame_valid,
    output logic   frame_ready,
    input  frame_t frame,
    output logic   push_valid,
    input  logic   push_ready,
    output alert_t push_data
);

    localparam int SEARCH_LEN = (OUI_ENTRIES < ROM_LEN) ? OUI_ENTRIES : ROM_LEN;

    logic              fv_reg;
    logic              fv_next;
    alert_t            fdata_reg;
    logic              take;
    logic              to_ds;
    logic              from_ds;
    logic [ADDR_W-1:0] sta;
    logic [ADDR_W-1:0] bssid;
    logic [OUI_W-1:0]  oui;
    logic              any_match;
    logic [VID_W-1:0]  vid;
    logic              header_ok;
    logic              hit;
    alert_t            result;

    assign to_ds   = frame.frame_ctrl_hi[0];
    assign from_ds = frame.frame_ctrl_hi[1];

    always_comb
    begin
        if (!to_ds && !from_ds)
        begin
            bssid = frame.address_three;
            sta   = frame.address_two;
        end
        else if (from_ds)
        begin
            bssid = frame.address_two;
            sta   = frame.address_one;
        end
        else
        begin
            bssid = frame.address_one;
            sta   = frame.address_two;
        end
    end

    assign oui = sta[ADDR_W-1 -: OUI_W];

    // The ROM entries are all distinct, so at most one compare fires and an
    // OR over the masked ids picks the winner.
    always_comb
    begin
        any_match = 1'b0;
        vid       = '0;
        for (int i = 0; i < SEARCH_LEN; i++)
        begin
            if (ROM_OUI[i] == oui)
            begin
                any_match = 1'b1;
                vid       = vid | ROM_VID[i];
            end
        end
    end

    assign header_ok = frame.is_data_packet
                    && (frame.frame_length >= MIN_FRAME_LEN)
                    && (frame.frame_ctrl_lo[3:2] == TYPE_DATA)
                    && !(to_ds && from_ds);

    assign hit = header_ok && !sta[GROUP_BIT] && !bssid[GROUP_BIT]
              && !sta[LOCAL_BIT] && any_match;

    always_comb
    begin
        result.station_addr = sta;
        result.network_id   = bssid;
        result.vendor_id    = vid;
        result.channel_out  = frame.radio_channel;
        result.rssi_out     = frame.signal_strength;
    end

    assign frame_ready = !fv_reg || push_ready;
    assign take        = frame_valid && frame_ready;

    always_comb
    begin
        if (take)
        begin
            fv_next = hit;
        end
        else if (push_ready)
        begin
            fv_next = 1'b0;
        end
        else
        begin
            fv_next = fv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fdata_reg <= result;
        end
    end

    assign push_valid = fv_reg;
    assign push_data  = fdata_reg;

`ifndef NO_ASSERTIONS
    a_drop_leaves_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !hit) |=> !fv_reg)
        else $error("dropped frame produced a queued word");
`endif

endmodule

### hdl/wdof_queue.sv
`timescale 1ns / 1ps

module wdof_queue
    import wdof_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  alert_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output alert_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    alert_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg < CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

### hdl/wdof_back.sv
`timescale 1ns / 1ps

module wdof_back
    import wdof_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pop_valid,
    output logic   pop_ready,
    input  alert_t pop_data,
    output logic   alert_valid,
    input  logic   alert_ready,
    output alert_t alert
);

    logic   out_valid_reg;
    logic   out_valid_next;
    alert_t alert_reg;
    logic   load;

    assign pop_ready = !out_valid_reg || alert_ready;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (alert_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            alert_reg <= pop_data;
        end
    end

    assign alert_valid = out_valid_reg;
    assign alert       = alert_reg;

endmodule

### hdl/wifi_data_frame_oui_filter_unit.sv
`timescale 1ns / 1ps
// Path: a matching header is registered in the classify register, written into the
// two-word queue and loaded into the output register, where it is presented as an
// alert word.
// Throughput: one header word per cycle while the queue has room or the classify register
// is empty; the OUI lookup is a parallel compare against the constant vendor ROM.
// Reset: rst_n is asynchronous and active low; it empties all stages and the queue.

module wifi_data_frame_oui_filter_unit
    import wdof_pkg::*;
#(
    parameter int OUI_ENTRIES = OUI_ENTRIES_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   frame_valid,
    output logic   frame_ready,
    input  frame_t frame,
    output logic   alert_valid,
    input  logic   alert_ready,
    output alert_t alert
);

    // Front to queue.
    logic   push_valid;
    logic   push_ready;
    alert_t push_data;

    // Queue to back end.
    logic   pop_valid;
    logic   pop_ready;
    alert_t pop_data;

    // The front end checks the header, picks the station and BSSID from the
    // ToDS/FromDS bits, looks up the station OUI and registers only the
    // headers that raise an alert. Dropped headers never enter the queue.
    wdof_front #(
        .OUI_ENTRIES (OUI_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // The short queue lets the front keep classifying while the consumer
    // holds off an alert word.
    wdof_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back end owns the output register and presents alert words.
    wdof_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .alert_valid (alert_valid),
        .alert_ready (alert_ready),
        .alert       (alert)
    );

endmodule
